// ===== rtl/upcr_pkg.sv =====
// Shared types, constants and codes of the UDP frame classifier and registrar.
package upcr_pkg;

  // Default sizes handed to the top level parameters.
  localparam int unsigned SlotsDefault    = 4;
  localparam int unsigned HdrBytesDefault = 128;

  // Frame layout.
  localparam int unsigned EthLen        = 14;
  localparam int unsigned IpMinEnd      = 34;
  localparam int unsigned OffEthTypeHi  = 12;
  localparam int unsigned OffEthTypeLo  = 13;
  localparam int unsigned OffIhl        = 14;
  localparam int unsigned OffProto      = 23;
  localparam int unsigned OffSrcAddr    = 26;
  localparam int unsigned UdpHdrLen     = 8;
  localparam int unsigned UdpWithWeight = 12;

  localparam logic [15:0] EthTypeIpv4 = 16'h0800;
  localparam logic [7:0]  ProtoUdp    = 8'd17;

  // Configuration registers.
  localparam int unsigned CfgDataW = 16;
  typedef logic [0:0] cfg_idx_t;
  localparam cfg_idx_t CFG_REGISTER_PORT = 1'b0;
  localparam cfg_idx_t CFG_TUNNEL_PORT   = 1'b1;

  localparam logic [15:0] RegisterPortReset = 16'd3000;
  localparam logic [15:0] TunnelPortReset   = 16'd2152;

  // Outcome codes of a result item.
  typedef logic [2:0] outcome_t;
  localparam outcome_t OUTCOME_OTHER = 3'd0;
  localparam outcome_t OUTCOME_SHORT = 3'd1;
  localparam outcome_t OUTCOME_REG   = 3'd2;
  localparam outcome_t OUTCOME_FULL  = 3'd3;
  localparam outcome_t OUTCOME_COUNT = 3'd4;

  // Input item: one frame byte.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  // Result item: one verdict per frame.
  typedef struct packed {
    logic        verdict;
    outcome_t    outcome;
    logic [1:0]  slot;
    logic [63:0] packet_total;
  } out_item_t;

  // Per-frame summary handed from the parser to the classifier.
  typedef struct packed {
    logic        pass_other;
    logic        short_payload;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [31:0] src_addr;
    logic [31:0] weight;
  } frame_sum_t;

endpackage

// ===== rtl/upcr_stream_if.sv =====
// Valid/ready stream interface that carries one item per handshake.
interface upcr_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/upcr_frame_parse.sv =====
// Byte stream parser: counts frame bytes, captures header fields, summarizes each frame.
module upcr_frame_parse #(
  parameter int unsigned HdrBytes = upcr_pkg::HdrBytesDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  upcr_pkg::in_item_t   in_item_i,
  output logic                 in_ready_o,
  output logic                 sum_valid_o,
  output upcr_pkg::frame_sum_t sum_o,
  input  logic                 sum_ack_i
);
  import upcr_pkg::*;

  localparam int unsigned LenW = $clog2(HdrBytes + 1);
  typedef logic [LenW-1:0] len_t;

  len_t        cnt_q;
  logic [15:0] eth_q, eth_d;
  logic [3:0]  ihl_q, ihl_d;
  logic [7:0]  proto_q, proto_d;
  logic [31:0] src_q, src_d;
  logic [15:0] sport_q, sport_d;
  logic [15:0] dport_q, dport_d;
  logic [31:0] weight_q, weight_d;
  logic        sum_valid_q;
  frame_sum_t  sum_q, sum_d;

  logic       accept;
  logic [7:0] cur;
  len_t       len_now;
  len_t       udp_off;
  len_t       udp_fin;
  len_t       rel;
  logic       in_udp;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = !sum_valid_q || sum_ack_i;
  assign cur        = in_item_i.data_byte;

  // Frame length including the current byte; it stops growing at the store size.
  assign len_now = (cnt_q < len_t'(HdrBytes)) ? cnt_q + len_t'(1) : cnt_q;

  // Field capture: each header byte lands in its field as it passes by.
  always_comb begin
    eth_d    = eth_q;
    proto_d  = proto_q;
    src_d    = src_q;
    sport_d  = sport_q;
    dport_d  = dport_q;
    weight_d = weight_q;
    ihl_d    = (cnt_q == len_t'(OffIhl)) ? cur[3:0] : ihl_q;

    if (cnt_q == len_t'(OffEthTypeHi)) eth_d[15:8] = cur;
    if (cnt_q == len_t'(OffEthTypeLo)) eth_d[7:0]  = cur;
    if (cnt_q == len_t'(OffProto))     proto_d     = cur;
    for (int k = 0; k < 4; k++) begin
      if (cnt_q == len_t'(OffSrcAddr + k)) src_d[31 - 8*k -: 8] = cur;
    end

    // The UDP header may overlap the IPv4 header when the IHL is small.
    udp_off = len_t'(EthLen) + len_t'({ihl_d, 2'b00});
    in_udp  = cnt_q >= udp_off;
    rel     = cnt_q - udp_off;
    if (in_udp) begin
      case (rel)
        len_t'(0): sport_d[15:8] = cur;
        len_t'(1): sport_d[7:0]  = cur;
        len_t'(2): dport_d[15:8] = cur;
        len_t'(3): dport_d[7:0]  = cur;
        default: ;
      endcase
      // The payload weight is little-endian.
      for (int k = 0; k < 4; k++) begin
        if (rel == len_t'(UdpHdrLen + k)) weight_d[8*k +: 8] = cur;
      end
    end
  end

  // Frame summary, taken from the fields as they stand after the final byte.
  always_comb begin
    udp_fin             = len_t'(EthLen) + len_t'({ihl_d, 2'b00});
    sum_d.pass_other    = (len_now < len_t'(EthLen)) || (eth_d != EthTypeIpv4) ||
                          (len_now < len_t'(IpMinEnd)) || (proto_d != ProtoUdp) ||
                          ((udp_fin + len_t'(UdpHdrLen)) > len_now);
    sum_d.short_payload = (udp_fin + len_t'(UdpWithWeight)) > len_now;
    sum_d.sport         = sport_d;
    sum_d.dport         = dport_d;
    sum_d.src_addr      = src_d;
    sum_d.weight        = weight_d;
  end

  // Byte counter and summary handshake.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      sum_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        cnt_q <= in_item_i.last_byte ? len_t'(0) : len_now;
      end
      if (accept && in_item_i.last_byte) begin
        sum_valid_q <= 1'b1;
      end else if (sum_ack_i) begin
        sum_valid_q <= 1'b0;
      end
    end
  end

  // Captured fields and the summary register.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      eth_q    <= eth_d;
      ihl_q    <= ihl_d;
      proto_q  <= proto_d;
      src_q    <= src_d;
      sport_q  <= sport_d;
      dport_q  <= dport_d;
      weight_q <= weight_d;
      if (in_item_i.last_byte) begin
        sum_q <= sum_d;
      end
    end
  end

  assign sum_valid_o = sum_valid_q;
  assign sum_o       = sum_q;

endmodule

// ===== rtl/upcr_classify.sv =====
// Verdict logic: port registers, registration table, tunnel counter and result register.
module upcr_classify #(
  parameter int unsigned Slots = upcr_pkg::SlotsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  upcr_pkg::cfg_idx_t            cfg_idx_i,
  input  logic [upcr_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          sum_valid_i,
  input  upcr_pkg::frame_sum_t          sum_i,
  output logic                          sum_ack_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output upcr_pkg::out_item_t           out_item_o
);
  import upcr_pkg::*;

  localparam int unsigned SlotIdxW = (Slots > 1) ? $clog2(Slots) : 1;
  typedef logic [SlotIdxW-1:0] slot_idx_t;

  logic [15:0]      reg_port_q;
  logic [15:0]      tun_port_q;
  logic [63:0]      count_q;
  logic [Slots-1:0] slot_free_q;
  logic [31:0]      slot_addr_q   [Slots];
  logic [31:0]      slot_weight_q [Slots];
  logic [15:0]      slot_sport_q  [Slots];
  logic             out_valid_q;
  out_item_t        out_q, res;

  logic        fire;
  logic        any_free;
  slot_idx_t   free_idx;
  logic        do_reg;
  logic        do_count;
  logic [63:0] count_inc;

  assign fire      = sum_valid_i && (!out_valid_q || out_ready_i);
  assign sum_ack_o = fire;
  assign count_inc = count_q + 64'd1;

  // Lowest-numbered free slot.
  always_comb begin
    any_free = 1'b0;
    free_idx = '0;
    for (int i = Slots - 1; i >= 0; i--) begin
      if (slot_free_q[i]) begin
        any_free = 1'b1;
        free_idx = slot_idx_t'(i);
      end
    end
  end

  // Verdict for the pending frame.
  always_comb begin
    do_reg   = 1'b0;
    do_count = 1'b0;
    res.verdict = 1'b0;
    res.outcome = OUTCOME_OTHER;
    res.slot    = 2'd0;
    if (sum_i.pass_other) begin
      res.outcome = OUTCOME_OTHER;
    end else if (sum_i.short_payload) begin
      res.verdict = 1'b1;
      res.outcome = OUTCOME_SHORT;
    end else if (sum_i.dport == reg_port_q) begin
      res.verdict = 1'b1;
      if (any_free) begin
        do_reg      = 1'b1;
        res.outcome = OUTCOME_REG;
        res.slot    = 2'(free_idx);
      end else begin
        res.outcome = OUTCOME_FULL;
      end
    end else if (sum_i.dport == tun_port_q) begin
      do_count    = 1'b1;
      res.outcome = OUTCOME_COUNT;
    end
    res.packet_total = do_count ? count_inc : count_q;
  end

  // Control state: configuration, counter, free bits and result valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reg_port_q  <= RegisterPortReset;
      tun_port_q  <= TunnelPortReset;
      count_q     <= '0;
      slot_free_q <= '1;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_REGISTER_PORT: reg_port_q <= cfg_data_i;
          CFG_TUNNEL_PORT:   tun_port_q <= cfg_data_i;
        endcase
      end
      if (fire && do_count) begin
        count_q <= count_inc;
      end
      // A zero source address leaves the slot free.
      if (fire && do_reg) begin
        slot_free_q[free_idx] <= (sum_i.src_addr == 32'd0);
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Table contents and the result payload.
  always_ff @(posedge clk_i) begin
    if (fire && do_reg) begin
      slot_addr_q[free_idx]   <= sum_i.src_addr;
      slot_weight_q[free_idx] <= sum_i.weight;
      slot_sport_q[free_idx]  <= sum_i.sport;
    end
    if (fire) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// ===== rtl/udp_packet_classifier_registrar.sv =====
// Throughput: one byte per cycle, also across frame boundaries; a held result stalls input
// only when the frame summary register is also full.
// The final byte loads the capture and summary registers together; the result register is
// loaded from the summary register once it is empty or its item is taken. Reset clears the
// byte count, the tunnel counter and all table slots to free, and loads the registration
// port with 3000 and the tunnel port with 2152.
module udp_packet_classifier_registrar #(
  parameter int unsigned Slots    = upcr_pkg::SlotsDefault,
  parameter int unsigned HdrBytes = upcr_pkg::HdrBytesDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  upcr_pkg::cfg_idx_t            cfg_idx_i,
  input  logic [upcr_pkg::CfgDataW-1:0] cfg_data_i,
  upcr_stream_if.sink                   in_if,
  upcr_stream_if.source                 out_if
);
  import upcr_pkg::*;

  logic       sum_valid;
  logic       sum_ack;
  frame_sum_t sum;
  logic       in_ready;
  logic       out_valid;
  out_item_t  out_item;

  // Byte capture and frame summary.
  upcr_frame_parse #(
    .HdrBytes (HdrBytes)
  ) u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_item_i   (in_if.payload),
    .in_ready_o  (in_ready),
    .sum_valid_o (sum_valid),
    .sum_o       (sum),
    .sum_ack_i   (sum_ack)
  );

  // Verdict, table and counter.
  upcr_classify #(
    .Slots (Slots)
  ) u_classify (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .sum_valid_i (sum_valid),
    .sum_i       (sum),
    .sum_ack_o   (sum_ack),
    .out_valid_o (out_valid),
    .out_ready_i (out_if.ready),
    .out_item_o  (out_item)
  );

  assign in_if.ready    = in_ready;
  assign out_if.valid   = out_valid;
  assign out_if.payload = out_item;

endmodule

// ===== rtl/upcr_checker.sv =====
// Port-level checks on the result stream of the classifier, bound to the top level.
module upcr_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input upcr_pkg::out_item_t out_item_i
);
  import upcr_pkg::*;

  logic [63:0] last_total_q;
  logic        seen_q;

  // Count carried by the last delivered item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q       <= 1'b0;
      last_total_q <= '0;
    end else if (out_valid_i && out_ready_i) begin
      seen_q       <= 1'b1;
      last_total_q <= out_item_i.packet_total;
    end
  end

  // A stalled item stays offered.
  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result valid dropped while stalled");

  // A stalled item keeps its payload.
  a_payload_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_item_i))
    else $error("result payload changed while stalled");

  // Verdict and slot agree with the outcome code.
  a_outcome_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |->
      (out_item_i.verdict == ((out_item_i.outcome == OUTCOME_SHORT) ||
                              (out_item_i.outcome == OUTCOME_REG) ||
                              (out_item_i.outcome == OUTCOME_FULL))) &&
      ((out_item_i.outcome == OUTCOME_REG) || (out_item_i.slot == 2'd0)) &&
      ((out_item_i.outcome == OUTCOME_OTHER) || (out_item_i.outcome == OUTCOME_SHORT) ||
       (out_item_i.outcome == OUTCOME_REG) || (out_item_i.outcome == OUTCOME_FULL) ||
       (out_item_i.outcome == OUTCOME_COUNT)))
    else $error("verdict, slot and outcome disagree");

  // The count grows by one exactly on counted frames.
  a_total_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && seen_q |->
      out_item_i.packet_total ==
        last_total_q + 64'(out_item_i.outcome == OUTCOME_COUNT))
    else $error("packet total out of step with counted frames");

endmodule

bind udp_packet_classifier_registrar upcr_checker u_upcr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_if.valid),
  .out_ready_i (out_if.ready),
  .out_item_i  (out_if.payload)
);
